/* rtl/core/utxm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package utxm_pkg;

   // Field widths fixed by the word format
   localparam int SLOT_BITS  = 8;
   localparam int CODE_BITS  = 21;
   localparam int WIDTH_BITS = 8;
   localparam int BYTE_BITS  = 8;

   // Default sizing handed to the top level
   localparam int DEF_TABLE_DEPTH = 256;
   localparam int DEF_COORD_BITS  = 16;

   // Work queue between decoder and measurement engine
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;

   // Register index codes
   localparam logic [1:0] CSR_GLYPH_COUNT  = 2'd0;
   localparam logic [1:0] CSR_CHAR_SPACING = 2'd1;
   localparam logic [1:0] CSR_LINE_STEP    = 2'd2;

   // Input word kind
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TEXT = 1'b1;

   // Special bytes and UTF-8 lead masks
   localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
   localparam logic [7:0] BYTE_TAG     = 8'h40;
   localparam logic [7:0] BYTE_ASCII   = 8'h80;
   localparam logic [7:0] LEAD2_MASK   = 8'hE0;
   localparam logic [7:0] LEAD2_CODE   = 8'hC0;
   localparam logic [7:0] LEAD3_MASK   = 8'hF0;
   localparam logic [7:0] LEAD3_CODE   = 8'hE0;
   localparam logic [7:0] LEAD4_MASK   = 8'hF8;
   localparam logic [7:0] LEAD4_CODE   = 8'hF0;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_GLYPH   = 2'd1,
      OP_NEWLINE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic                    last;
      logic [SLOT_BITS-1:0]    slot;
      logic [CODE_BITS-1:0]    code;
      logic [WIDTH_BITS-1:0]   width;
   } entry_type;

   typedef struct packed {
      logic [8:0]        glyph_count;
      logic signed [3:0] char_spacing;
      logic [5:0]        line_step;
   } cfg_type;

endpackage
`default_nettype wire

/* rtl/core/utf8_text_extent_measure.sv */
`timescale 1ns / 1ps
`default_nettype none
// UTF-8 text extent measure. Each req word is either a glyph table load
// (tuser low: slot, code point and width) or one byte of a UTF-8 string
// (tuser high, tlast on the final byte). The front end decodes bytes
// (newline, '@'-delimited tags, multi-byte sequences) one word per cycle
// unless the queue is full, and posts work into a four-deep queue; the
// back end keeps the pen and does the glyph lookup by binary search over
// the loaded table, one probe per cycle out of a registered-read memory.
// A character goes through search, (on a match) advance and finish; the
// final byte of a string goes through report and hands {final_y,
// max_width} to an output register that decouples rsp_tready from the
// engine. The table must be loaded in ascending code point order and
// glyph_count set to the number of valid entries; unwritten entries read
// back as garbage. The user changes registers only while the block is
// idle; the block itself does not enforce this.
module utf8_text_extent_measure #(
   parameter int TABLE_DEPTH = utxm_pkg::DEF_TABLE_DEPTH,
   parameter int COORD_BITS  = utxm_pkg::DEF_COORD_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input word channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] glyph_slot, [28:8] glyph_code, [36:29] glyph_width,
   // [44:37] text_byte, [47:45] zero
   input  wire logic [47:0] req_tdata,
   input  wire logic        req_tuser,  // [0] command: 0 load, 1 text byte
   input  wire logic        req_tlast,  // last_byte
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [14:0] max_width, [30:15] final_y, [31] zero
   output logic [31:0]      rsp_tdata,
   // register writes
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_wdata
);
   import utxm_pkg::*;

   cfg_type   cfg_ff;
   entry_type push_data, pop_data;
   logic      q_push, q_pop, q_full, q_empty;

   // register file: reset to 0 glyphs, spacing 1, line step 16
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.glyph_count  <= 9'd0;
         cfg_ff.char_spacing <= 4'sd1;
         cfg_ff.line_step    <= 6'd16;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GLYPH_COUNT:  cfg_ff.glyph_count  <= csr_wdata;
            CSR_CHAR_SPACING: cfg_ff.char_spacing <= csr_wdata[3:0];
            CSR_LINE_STEP:    cfg_ff.line_step    <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // decode bytes, drop what lays out nothing
   utxm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_cmd   (req_tuser),
      .in_last  (req_tlast),
      .in_slot  (req_tdata[7:0]),
      .in_code  (req_tdata[28:8]),
      .in_width (req_tdata[36:29]),
      .in_byte  (req_tdata[44:37]),
      .in_ready (req_tready),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (push_data)
   );

   // hold decoded work while the engine searches
   utxm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // table, lookup, pen and report
   utxm_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COORD_BITS  (COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (pop_data),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule
`default_nettype wire

/* rtl/core/utxm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module utxm_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic                in_cmd,
   input  wire logic                in_last,
   input  wire logic [7:0]          in_slot,
   input  wire logic [20:0]         in_code,
   input  wire logic [7:0]          in_width,
   input  wire logic [7:0]          in_byte,
   output logic                     in_ready,
   input  wire logic                q_full,
   output logic                     q_push,
   output utxm_pkg::entry_type      q_data
);
   import utxm_pkg::*;

   logic [CODE_BITS-1:0] partial_ff, partial_in;
   logic [1:0]           pending_ff, pending_in;
   logic                 tag_ff, tag_in;
   logic                 take;
   entry_type            ent;

   assign in_ready = !q_full;
   assign take     = in_valid && !q_full;

   always_comb begin
      partial_in = partial_ff;
      pending_in = pending_ff;
      tag_in     = tag_ff;
      ent.op     = OP_NONE;
      ent.last   = 1'b0;
      ent.slot   = in_slot;
      ent.code   = in_code;
      ent.width  = in_width;
      if (in_cmd == CMD_LOAD) begin
         ent.op = OP_LOAD;
      end else begin
         ent.last = in_last;
         if (pending_ff != 2'd0) begin
            // continuation: any byte, low six bits
            partial_in = {partial_ff[CODE_BITS-7:0], in_byte[5:0]};
            pending_in = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               ent.op   = OP_GLYPH;
               ent.code = partial_in;
            end
         end else if (tag_ff) begin
            if (in_byte == BYTE_TAG) tag_in = 1'b0;
         end else if (in_byte == BYTE_NEWLINE) begin
            ent.op = OP_NEWLINE;
         end else if (in_byte == BYTE_TAG) begin
            tag_in = 1'b1;
         end else if (in_byte < BYTE_ASCII) begin
            ent.op   = OP_GLYPH;
            ent.code = {13'd0, in_byte};
         end else if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
            partial_in = {16'd0, in_byte[4:0]};
            pending_in = 2'd1;
         end else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) begin
            partial_in = {17'd0, in_byte[3:0]};
            pending_in = 2'd2;
         end else if ((in_byte & LEAD4_MASK) == LEAD4_CODE) begin
            partial_in = {18'd0, in_byte[2:0]};
            pending_in = 2'd3;
         end
         // end of string: drop any cut-off character or open tag
         if (in_last) begin
            partial_in = '0;
            pending_in = 2'd0;
            tag_in     = 1'b0;
         end
      end
   end

   assign q_push = take && (ent.op != OP_NONE || ent.last);
   assign q_data = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         pending_ff <= 2'd0;
         tag_ff     <= 1'b0;
      end else if (take) begin
         partial_ff <= partial_in;
         pending_ff <= pending_in;
         tag_ff     <= tag_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/utxm_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module utxm_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  utxm_pkg::entry_type      push_data,
   input  wire logic                pop,
   output utxm_pkg::entry_type      pop_data,
   output logic                     full,
   output logic                     empty
);
   import utxm_pkg::*;

   entry_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_BITS:0]   count_ff, count_in;

   assign full     = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/utxm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module utxm_back #(
   parameter int TABLE_DEPTH = utxm_pkg::DEF_TABLE_DEPTH,
   parameter int COORD_BITS  = utxm_pkg::DEF_COORD_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  utxm_pkg::cfg_type        cfg,
   input  wire logic                q_empty,
   input  utxm_pkg::entry_type      q_data,
   output logic                     q_pop,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [31:0]              out_data
);
   import utxm_pkg::*;

   localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam int SUM_BITS = COORD_BITS + 2;
   localparam logic signed [32:0] REP_MAX = 33'sd32767;
   localparam logic signed [32:0] REP_MIN = -33'sd32768;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_SEARCH  = 5'b00010,
      S_ADVANCE = 5'b00100,
      S_FINISH  = 5'b01000,
      S_REPORT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [CODE_BITS-1:0]  code_mem_ff  [TABLE_DEPTH];
   logic [WIDTH_BITS-1:0] width_mem_ff [TABLE_DEPTH];
   logic [CODE_BITS-1:0]  rd_code_ff;
   logic [WIDTH_BITS-1:0] rd_width_ff;
   logic                  mem_rd, mem_wr;
   logic [IDX_BITS-1:0]   rd_addr, wr_addr;

   logic [CNT_BITS-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_BITS-1:0]   mid_ff, mid_in;
   logic [CODE_BITS-1:0]  code_ff, code_in;
   logic                  last_ff, last_in;
   logic [WIDTH_BITS-1:0] found_ff, found_in;

   logic signed [COORD_BITS-1:0] pen_x_ff, pen_x_in;
   logic signed [COORD_BITS-1:0] pen_y_ff, pen_y_in;
   logic signed [COORD_BITS-1:0] widest_ff, widest_in;

   logic                  out_valid_ff, out_valid_in;
   logic [31:0]           out_data_ff, out_data_in;

   logic [CNT_BITS-1:0]   count;
   logic [CNT_BITS-1:0]   lo_next, hi_next;
   logic signed [SUM_BITS-1:0] adv_sum, nl_sum;
   logic signed [32:0]    wide_ext, y_ext;
   logic [14:0]           rep_w;
   logic [15:0]           rep_y;

   function automatic logic [IDX_BITS-1:0] mid_of(input logic [CNT_BITS-1:0] lo,
                                                  input logic [CNT_BITS-1:0] hi);
      logic [CNT_BITS:0] s;
      s = (CNT_BITS+1)'(lo) + (CNT_BITS+1)'(hi) - (CNT_BITS+1)'(1);
      return IDX_BITS'(s >> 1);
   endfunction

   function automatic logic signed [COORD_BITS-1:0] sat_coord(
         input logic signed [SUM_BITS-1:0] v);
      if (v[SUM_BITS-1:COORD_BITS-1] == {(SUM_BITS-COORD_BITS+1){v[SUM_BITS-1]}})
         return v[COORD_BITS-1:0];
      else if (v[SUM_BITS-1])
         return {1'b1, {(COORD_BITS-1){1'b0}}};
      else
         return {1'b0, {(COORD_BITS-1){1'b1}}};
   endfunction

   // clamp glyph_count to table depth
   assign count = (32'(cfg.glyph_count) > 32'(TABLE_DEPTH)) ?
                  CNT_BITS'(TABLE_DEPTH) : CNT_BITS'(cfg.glyph_count);

   assign adv_sum = SUM_BITS'(pen_x_ff) + SUM_BITS'($signed({1'b0, found_ff}))
                  + SUM_BITS'($signed(cfg.char_spacing));
   assign nl_sum  = SUM_BITS'(pen_y_ff) - SUM_BITS'($signed({1'b0, cfg.line_step}));

   assign wide_ext = 33'(widest_ff);
   assign y_ext    = 33'(pen_y_ff);
   assign rep_w    = (wide_ext > REP_MAX) ? 15'h7FFF : wide_ext[14:0];
   assign rep_y    = (y_ext < REP_MIN) ? 16'h8000 :
                     (y_ext > REP_MAX) ? 16'h7FFF : y_ext[15:0];

   assign lo_next = (code_ff < rd_code_ff) ? lo_ff : CNT_BITS'(mid_ff) + CNT_BITS'(1);
   assign hi_next = (code_ff < rd_code_ff) ? CNT_BITS'(mid_ff) : hi_ff;

   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      mem_rd       = 1'b0;
      mem_wr       = 1'b0;
      rd_addr      = mid_ff;
      wr_addr      = IDX_BITS'(q_data.slot);
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      code_in      = code_ff;
      last_in      = last_ff;
      found_in     = found_ff;
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      widest_in    = widest_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_data_in  = out_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               code_in = q_data.code;
               last_in = q_data.last;
               case (q_data.op)
                  OP_LOAD: begin
                     // slots past the table are dropped
                     mem_wr = (32'(q_data.slot) < 32'(TABLE_DEPTH));
                  end
                  OP_NEWLINE: begin
                     pen_x_in = '0;
                     pen_y_in = sat_coord(nl_sum);
                     if (q_data.last) state_in = S_REPORT;
                  end
                  OP_GLYPH: begin
                     lo_in = '0;
                     hi_in = count;
                     if (count == '0) begin
                        state_in = S_FINISH;
                     end else begin
                        mid_in   = mid_of('0, count);
                        rd_addr  = mid_in;
                        mem_rd   = 1'b1;
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     if (q_data.last) state_in = S_REPORT;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (code_ff == rd_code_ff) begin
               found_in = rd_width_ff;
               state_in = S_ADVANCE;
            end else begin
               lo_in = lo_next;
               hi_in = hi_next;
               if (lo_next < hi_next) begin
                  mid_in  = mid_of(lo_next, hi_next);
                  rd_addr = mid_in;
                  mem_rd  = 1'b1;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_ADVANCE: begin
            pen_x_in = sat_coord(adv_sum);
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (pen_x_ff > widest_ff) widest_in = pen_x_ff;
            state_in = last_ff ? S_REPORT : S_IDLE;
         end
         S_REPORT: begin
            // hold until the output register frees up
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               out_data_in  = {1'b0, rep_y, rep_w};
               pen_x_in     = '0;
               pen_y_in     = '0;
               widest_in    = '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         code_mem_ff[wr_addr]  <= q_data.code;
         width_mem_ff[wr_addr] <= q_data.width;
      end
      if (mem_rd) begin
         rd_code_ff  <= code_mem_ff[rd_addr];
         rd_width_ff <= width_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      code_ff     <= code_in;
      last_ff     <= last_in;
      found_ff    <= found_in;
      out_data_ff <= out_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         widest_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         widest_ff    <= widest_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule
`default_nettype wire

/* rtl/core/utxm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module utxm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // a stalled result holds its word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed under stall");

   // pen y only moves down, so final_y never goes positive
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[30] || rsp_tdata[30:15] == 16'd0))
      else $error("final_y positive");

   // reset empties the output register and the queue
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("state left over after reset");

   // spare bit of the result word stays zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[31])
      else $error("result padding bit set");

endmodule

bind utf8_text_extent_measure utxm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
